>>> hw/rtl/mfb_pkg.sv
// shared types, codes and constants of the framebuffer draw engine
`default_nettype none

package mfb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_STORE_BYTES   = 1024;

    // widest byte index a coordinate pair can map to: 255 + 31 * 256
    localparam int IDX_W  = 13;
    localparam int CMP_W  = IDX_W + 1;
    localparam int ADDR_W = 10;
    localparam int COORD_W = 8;

    typedef enum logic [2:0] {
        OP_PIXEL = 3'd0,
        OP_HLINE = 3'd1,
        OP_VLINE = 3'd2,
        OP_RECT  = 3'd3,
        OP_FILL  = 3'd4,
        OP_CLEAR = 3'd5,
        OP_READ  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POINT,
        ST_RUN,
        ST_FILL,
        ST_CLEAR
    } seq_state_t;

    typedef enum logic [1:0] {
        REQ_WRITE,
        REQ_CLEAR,
        REQ_READ
    } req_kind_t;

    typedef struct packed {
        logic             valid;
        req_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [2:0]       bit_sel;
        logic             on;
        logic             in_range;
    } pix_req_t;

    typedef struct packed {
        logic              valid;
        logic              pending;
        logic [ADDR_W-1:0] idx;
        logic [7:0]        data;
    } rd_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/mfb_if.sv
// command and byte channel interfaces of the framebuffer draw engine
`default_nettype none

interface mfb_cmd_if import mfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COORD_W-1:0] run_length;
    logic               pixel_on;
    logic [ADDR_W-1:0]  read_address;

    modport source (
        output valid, operation, x_start, y_start, x_end, y_end, run_length,
               pixel_on, read_address,
        input  ready
    );

    modport sink (
        input  valid, operation, x_start, y_start, x_end, y_end, run_length,
               pixel_on, read_address,
        output ready
    );
endinterface

interface mfb_byte_if import mfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        byte_data;

    modport source (
        output valid, byte_index, byte_data,
        input  ready
    );

    modport sink (
        input  valid, byte_index, byte_data,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/mfb_seq.sv
// command sequencer: walks pixels of points, lines, rectangles, fills and clears, and issues byte reads
`default_nettype none

module mfb_seq import mfb_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mfb_cmd_if.sink    cmd,
    input  wire logic  out_block,
    output pix_req_t   req
);

    seq_state_t         state_reg, state_next;
    op_t                op_reg, op_next;
    logic [COORD_W-1:0] xs_reg, xs_next;
    logic [COORD_W-1:0] ys_reg, ys_next;
    logic [COORD_W-1:0] xe_reg, xe_next;
    logic [COORD_W-1:0] ye_reg, ye_next;
    logic [COORD_W-1:0] len_reg, len_next;
    logic [COORD_W-1:0] w_reg, w_next;
    logic [COORD_W-1:0] h_reg, h_next;
    logic               on_reg, on_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [COORD_W-1:0] i_reg, i_next;
    logic [COORD_W-1:0] j_reg, j_next;
    logic [1:0]         phase_reg, phase_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;

    logic [COORD_W-1:0] seg_x;
    logic [COORD_W-1:0] seg_y;
    logic               seg_vert;
    logic [COORD_W-1:0] seg_count;
    logic               seg_last;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               on_screen;
    logic [IDX_W-1:0]   pix_idx;
    logic               in_store;
    logic               accept;

    assign cmd.ready = (state_reg == ST_IDLE) && !out_block;
    assign accept    = cmd.valid && cmd.ready;

    // current segment of a line or of one rectangle side
    assign seg_x     = (phase_reg == 2'd3) ? xe_reg : xs_reg;
    assign seg_y     = (phase_reg == 2'd1) ? ye_reg : ys_reg;
    assign seg_vert  = (op_reg == OP_VLINE) || ((op_reg == OP_RECT) && phase_reg[1]);
    assign seg_count = (op_reg == OP_RECT) ? (phase_reg[1] ? h_reg : w_reg) : len_reg;
    assign seg_last  = (op_reg != OP_RECT) || (phase_reg == 2'd3);

    always_comb
    begin
        px = xs_reg;
        py = ys_reg;
        case (state_reg)
            ST_RUN:
            begin
                px = seg_vert ? seg_x : seg_x + i_reg;
                py = seg_vert ? seg_y + i_reg : seg_y;
            end
            ST_FILL:
            begin
                px = xs_reg + i_reg;
                py = ys_reg + j_reg;
            end
            default:
            begin
                px = xs_reg;
                py = ys_reg;
            end
        endcase
    end

    assign on_screen = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));
    assign pix_idx   = IDX_W'(px) + IDX_W'(py[7:3]) * IDX_W'(SCREEN_WIDTH);
    assign in_store  = {1'b0, pix_idx} < CMP_W'(STORE_BYTES);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        len_next   = len_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        on_next    = on_reg;
        addr_next  = addr_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        phase_next = phase_reg;
        clr_next   = clr_reg;

        req.valid    = 1'b0;
        req.kind     = REQ_WRITE;
        req.idx      = pix_idx;
        req.bit_sel  = py[2:0];
        req.on       = 1'b1;
        req.in_range = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(cmd.operation);
                    xs_next    = cmd.x_start;
                    ys_next    = cmd.y_start;
                    xe_next    = cmd.x_end;
                    ye_next    = cmd.y_end;
                    len_next   = cmd.run_length;
                    w_next     = cmd.x_end - cmd.x_start + 8'd1;
                    h_next     = cmd.y_end - cmd.y_start;
                    on_next    = cmd.pixel_on;
                    addr_next  = cmd.read_address;
                    i_next     = '0;
                    j_next     = '0;
                    phase_next = '0;
                    clr_next   = '0;
                    case (op_t'(cmd.operation))
                        OP_PIXEL: state_next = ST_POINT;
                        OP_READ:  state_next = ST_POINT;
                        OP_HLINE: state_next = ST_RUN;
                        OP_VLINE: state_next = ST_RUN;
                        OP_RECT:  state_next = ST_RUN;
                        OP_FILL:  state_next = ST_FILL;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POINT:
            begin
                state_next = ST_IDLE;
                if (op_reg == OP_READ)
                begin
                    req.valid    = 1'b1;
                    req.kind     = REQ_READ;
                    req.idx      = IDX_W'(addr_reg);
                    req.in_range = {4'b0, addr_reg} < CMP_W'(STORE_BYTES);
                end
                else
                begin
                    req.valid = on_screen && in_store;
                    req.on    = on_reg;
                end
            end
            ST_RUN:
            begin
                if (i_reg == seg_count)
                begin
                    i_next = '0;
                    if (seg_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
                else
                begin
                    req.valid = on_screen && in_store;
                    i_next    = i_reg + 8'd1;
                end
            end
            ST_FILL:
            begin
                if (w_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    req.valid = on_screen && in_store;
                    if (j_reg == h_reg)
                    begin
                        j_next = '0;
                        if (i_reg == w_reg - 8'd1)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 8'd1;
                    end
                end
            end
            ST_CLEAR:
            begin
                req.valid = 1'b1;
                req.kind  = REQ_CLEAR;
                req.idx   = clr_reg;
                if (clr_reg == IDX_W'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        xe_reg   <= xe_next;
        ye_reg   <= ye_next;
        len_reg  <= len_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        on_reg   <= on_next;
        addr_reg <= addr_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/mfb_rmw.sv
// frame store with read-modify-write pipe and write forwarding
`default_nettype none

module mfb_rmw import mfb_pkg::*; #(
    parameter int STORE_BYTES = DEF_STORE_BYTES
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pix_req_t req,
    output rd_result_t    rd
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0]       mem [STORE_BYTES];
    logic [7:0]       rdata_reg;

    logic             s1_valid_reg;
    pix_req_t         s1_reg;
    logic             last_valid_reg;
    logic [AW-1:0]    last_idx_reg;
    logic [7:0]       last_data_reg;

    logic [AW-1:0]    s1_addr;
    logic [7:0]       cur;
    logic [7:0]       mask;
    logic [7:0]       wdata;
    logic             wr_en;

    assign s1_addr = s1_reg.idx[AW-1:0];

    // the write of the previous cycle is not yet in the read data
    assign cur   = (last_valid_reg && (last_idx_reg == s1_addr)) ? last_data_reg : rdata_reg;
    assign mask  = 8'd1 << s1_reg.bit_sel;
    assign wr_en = s1_valid_reg && (s1_reg.kind != REQ_READ);

    always_comb
    begin
        case (s1_reg.kind)
            REQ_CLEAR: wdata = 8'd0;
            REQ_WRITE: wdata = s1_reg.on ? (cur | mask) : (cur & ~mask);
            default:   wdata = cur;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.idx[AW-1:0]];
        if (wr_en)
        begin
            mem[s1_addr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= req.valid;
            last_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg        <= req;
        last_idx_reg  <= s1_addr;
        last_data_reg <= wdata;
    end

    assign rd.valid   = s1_valid_reg && (s1_reg.kind == REQ_READ);
    assign rd.pending = rd.valid;
    assign rd.idx     = s1_reg.idx[ADDR_W-1:0];
    assign rd.data    = s1_reg.in_range ? cur : 8'd0;

endmodule

`default_nettype wire

>>> hw/rtl/mono_framebuffer_draw_engine_top.sv
// top level of the monochrome page-layout framebuffer draw engine
//
// cmd takes one command word per valid/ready handshake: pixel, horizontal or
// vertical line, rectangle outline, filled rectangle, clear, or byte read.
// rsp returns one word (byte_index, byte_data) for each byte read only.
// the image lives in one single-port-write memory of STORE_BYTES bytes; the
// sequencer issues one pixel per cycle into a two-stage read-modify-write
// pipe, and back-to-back hits on the same byte are forwarded.
// a command with an unused operation code is accepted and does nothing.
// a read word reaches rsp through the sequencer's point state, the pipe's
// stage register and the rsp output register.
// after reset the store is swept to zero, one byte a cycle, with cmd.ready
// low. while a read word waits on a stalled rsp, cmd.ready stays low, so
// nothing is lost.
`default_nettype none

module mono_framebuffer_draw_engine_top import mfb_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfb_cmd_if.sink     cmd,
    mfb_byte_if.source  rsp
);

    pix_req_t          req;
    rd_result_t        rd;
    logic              out_block;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_idx_reg;
    logic [7:0]        out_data_reg;

    assign out_block = rd.pending || (out_valid_reg && !rsp.ready);

    mfb_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STORE_BYTES   (STORE_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_block (out_block),
        .req       (req)
    );

    mfb_rmw #(
        .STORE_BYTES (STORE_BYTES)
    ) u_rmw (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rd    (rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rd.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.valid)
        begin
            out_idx_reg  <= rd.idx;
            out_data_reg <= rd.data;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.byte_index = out_idx_reg;
    assign rsp.byte_data  = out_data_reg;

endmodule

`default_nettype wire
